### hw/rtl/stereo_adaptive_gain_compressor_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo gain compressor
// Each macro expects clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef STEREO_ADAPTIVE_GAIN_COMPRESSOR_UNIT_ASSERT_SVH
`define STEREO_ADAPTIVE_GAIN_COMPRESSOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SAGC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SAGC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition that must never hold
`define SAGC_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

### hw/rtl/sagc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sagc_pkg
// Widths, fixed-point constants, command/status types and the series
// divisor table of the stereo gain compressor.
// ----------------------------------------------------------------------------
package sagc_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int GAIN_FRAC_BITS = 30;
	localparam int GAIN_BITS      = GAIN_FRAC_BITS + 4;
	localparam int WORD_BITS      = 64;

	// alignment shifts into and out of the Q0.62 domain
	localparam int A_SH  = 63 - SAMPLE_BITS;
	localparam int G_SH  = 62 - GAIN_FRAC_BITS;
	localparam int O_SH  = 62 - SAMPLE_BITS;
	localparam int SH_X  = 63;
	localparam int SH_Q  = 62;
	localparam int SH_D  = 124 - GAIN_FRAC_BITS;

	localparam logic [WORD_BITS-1:0] Q62_ONE  = 64'h4000_0000_0000_0000;
	// magnitude of sin(4) in Q0.62, applied with negative sign
	localparam logic [WORD_BITS-1:0] SIN4_MAG = 64'd3490135486322531555;

	localparam logic signed [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC_BITS;
	localparam logic signed [GAIN_BITS-1:0] GAIN_LO  = GAIN_BITS'(1) << (GAIN_FRAC_BITS - 7);

	// shared multiplier: 64x64 from four 32x32 partial products
	localparam int MUL_PARTS = 4;
	localparam int HALF_BITS = WORD_BITS / 2;

	// series divider: radix 16, divisor below 256
	localparam int SINE_TERMS = 6;
	localparam int TERM_BITS  = $clog2(SINE_TERMS);
	localparam int DIV_BITS   = 8;
	localparam int DIGIT_BITS = 4;
	localparam int RADIX      = 1 << DIGIT_BITS;
	localparam int DIV_DIGITS = WORD_BITS / DIGIT_BITS;
	localparam int DCNT_BITS  = $clog2(DIV_DIGITS);

	typedef enum logic [1:0] {
		MSH_X = 2'd0,
		MSH_Q = 2'd1,
		MSH_D = 2'd2
	} msh_t;

	// multiply operations, each with fixed operands and destination
	typedef enum logic [2:0] {
		MS_X  = 3'd0,  // x   = a62 * g62 >> 63
		MS_X2 = 3'd1,  // x^2
		MS_X4 = 3'd2,  // x^4
		MS_SN = 3'd3,  // sin(4) * x^4, subtracted
		MS_T2 = 3'd4,  // t^2
		MS_SM = 3'd5,  // t^2 * u, feeds divider
		MS_S  = 3'd6,  // t * u
		MS_SP = 3'd7   // s * x^4, added
	} msel_t;

	typedef struct packed {
		logic                 load;
		logic                 ch;
		logic                 mul_go;
		msel_t                msel;
		logic                 div_go;
		logic [TERM_BITS-1:0] div_idx;
		logic                 commit;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic t_big;
	} stat_t;

	function automatic logic [DIV_BITS-1:0] div_const(input logic [TERM_BITS-1:0] idx);
		logic [DIV_BITS-1:0] d;
		case (idx)
			3'd0:    d = 8'd156;
			3'd1:    d = 8'd110;
			3'd2:    d = 8'd72;
			3'd3:    d = 8'd42;
			3'd4:    d = 8'd20;
			3'd5:    d = 8'd6;
			default: d = 8'd6;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/stereo_adaptive_gain_compressor_unit.sv
// Per channel the short path runs when |4x| > 1, else the sine series path: each
// product runs on the shared 32x32 multiplier, and each of the six series terms adds
// a radix-16 division. A new pair is taken while the previous result waits.
// Reset: arst_n clears the sequencer and output valid, and sets the running gain to 1.0.
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_adaptive_gain_compressor_unit
// Stereo compressor with one shared adaptive gain: scales both channels by
// the clamped gain and moves the gain by s(|4x|) * x^4 per channel.
// ----------------------------------------------------------------------------
module stereo_adaptive_gain_compressor_unit (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic signed [sagc_pkg::SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [sagc_pkg::SAMPLE_BITS-1:0] right_in,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic signed [sagc_pkg::SAMPLE_BITS-1:0]      left_out,
	output logic signed [sagc_pkg::SAMPLE_BITS-1:0]      right_out
);

	sagc_pkg::cmd_t  cmd;
	sagc_pkg::stat_t stat;

	sagc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	sagc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.left_in   (left_in),
		.right_in  (right_in),
		.left_out  (left_out),
		.right_out (right_out)
	);

endmodule
`default_nettype wire

### hw/rtl/sagc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sagc_mul
// Shared 64x64 unsigned multiplier, one registered 32x32 partial product
// per cycle, result shifted right by one of three fixed amounts.
// ----------------------------------------------------------------------------
module sagc_mul (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           go,
	input  wire logic [sagc_pkg::WORD_BITS-1:0] a,
	input  wire logic [sagc_pkg::WORD_BITS-1:0] b,
	input  wire sagc_pkg::msh_t                 sh,
	output logic                                done,
	output logic [sagc_pkg::WORD_BITS-1:0]      res
);

	localparam int W  = sagc_pkg::WORD_BITS;
	localparam int H  = sagc_pkg::HALF_BITS;
	localparam logic [2:0] PP_LAST = 3'(sagc_pkg::MUL_PARTS);

	logic               busy_q;
	logic               done_q;
	logic [2:0]         cnt_q;
	logic [W-1:0]       a_q;
	logic [W-1:0]       b_q;
	sagc_pkg::msh_t     sh_q;
	logic [W-1:0]       pp_s1;
	logic [1:0]         psh_s1;
	logic [2*W-1:0]     acc_q;

	logic               start;
	logic [1:0]         k;
	logic [H-1:0]       ai;
	logic [H-1:0]       bi;
	logic [W-1:0]       pp;
	logic [1:0]         psh;
	logic [2*W-1:0]     ppw;
	logic [2*W-1:0]     shd;

	assign start = go && !busy_q && !done_q;

	always_comb begin
		k   = cnt_q[1:0];
		ai  = k[0] ? a_q[W-1:H] : a_q[H-1:0];
		bi  = k[1] ? b_q[W-1:H] : b_q[H-1:0];
		pp  = W'(ai) * W'(bi);
		psh = {k[0] & k[1], k[0] ^ k[1]};
		case (psh_s1)
			2'd0:    ppw = {{W{1'b0}}, pp_s1};
			2'd1:    ppw = {{H{1'b0}}, pp_s1, {H{1'b0}}};
			default: ppw = {pp_s1, {W{1'b0}}};
		endcase
	end

	always_comb begin
		case (sh_q)
			sagc_pkg::MSH_X: shd = acc_q >> sagc_pkg::SH_X;
			sagc_pkg::MSH_Q: shd = acc_q >> sagc_pkg::SH_Q;
			sagc_pkg::MSH_D: shd = acc_q >> sagc_pkg::SH_D;
			default:         shd = '0;
		endcase
		res = shd[W-1:0];
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == PP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial product registered, added into the accumulator in the next cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			sh_q  <= sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != PP_LAST) begin
				pp_s1  <= pp;
				psh_s1 <= psh;
			end
			if (cnt_q != 3'd0) begin
				acc_q <= acc_q + ppw;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/sagc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sagc_div
// Radix-16 long division of a 64-bit word by a small constant from the
// series divisor table, one quotient digit per cycle.
// ----------------------------------------------------------------------------
module sagc_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           go,
	input  wire logic [sagc_pkg::WORD_BITS-1:0] num,
	input  wire logic [sagc_pkg::TERM_BITS-1:0] idx,
	output logic                                done,
	output logic [sagc_pkg::WORD_BITS-1:0]      quo
);

	localparam int W  = sagc_pkg::WORD_BITS;
	localparam int DB = sagc_pkg::DIV_BITS;
	localparam int GB = sagc_pkg::DIGIT_BITS;
	localparam int R  = sagc_pkg::RADIX;
	localparam int CB = sagc_pkg::DCNT_BITS;
	localparam logic [CB-1:0] CNT_LAST = CB'(sagc_pkg::DIV_DIGITS - 1);

	logic           busy_q;
	logic           done_q;
	logic [CB-1:0]  cnt_q;
	logic [W-1:0]   n_q;
	logic [W-1:0]   q_q;
	logic [DB-1:0]  rem_q;
	logic [DB-1:0]  d_q;

	logic           start;
	logic [DB+GB-1:0] w;
	logic [DB+GB-1:0] mults [R];
	logic [GB-1:0]  qd;
	logic [DB-1:0]  rem_d;

	assign start = go && !busy_q && !done_q;

	// largest digit whose multiple of d fits the partial remainder
	always_comb begin
		w = {rem_q, n_q[W-1 -: GB]};
		for (int j = 0; j < R; j++) begin
			mults[j] = (DB+GB)'(j) * (DB+GB)'(d_q);
		end
		qd = '0;
		for (int j = 1; j < R; j++) begin
			if (mults[j] <= w) begin
				qd = GB'(j);
			end
		end
		rem_d = DB'(w - mults[qd]);
	end

	assign done = done_q;
	assign quo  = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CB'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			rem_q <= '0;
			d_q   <= sagc_pkg::div_const(idx);
		end else if (busy_q) begin
			n_q   <= {n_q[W-GB-1:0], {GB{1'b0}}};
			q_q   <= {q_q[W-GB-1:0], qd};
			rem_q <= rem_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/sagc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sagc_dp
// Datapath: sample and gain registers, operand selection for the shared
// multiplier, series divider, gain accumulation and result registers.
// ----------------------------------------------------------------------------
module sagc_dp (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire sagc_pkg::cmd_t                          cmd,
	output sagc_pkg::stat_t                              stat,
	input  wire logic signed [sagc_pkg::SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [sagc_pkg::SAMPLE_BITS-1:0] right_in,
	output logic signed [sagc_pkg::SAMPLE_BITS-1:0]      left_out,
	output logic signed [sagc_pkg::SAMPLE_BITS-1:0]      right_out
);

	localparam int SB = sagc_pkg::SAMPLE_BITS;
	localparam int GB = sagc_pkg::GAIN_BITS;
	localparam int W  = sagc_pkg::WORD_BITS;

	logic signed [GB-1:0] gain_q;
	logic [SB-1:0]        l_q;
	logic [SB-1:0]        r_q;
	logic [GB-1:0]        gcl_q;
	logic [GB-1:0]        gacc_q;
	logic [W-1:0]         x_q;
	logic [W-1:0]         x4_q;
	logic [W-1:0]         t2_q;
	logic [W-1:0]         u_q;
	logic [SB-1:0]        lres_q;
	logic [SB-1:0]        rres_q;
	logic [SB-1:0]        lout_q;
	logic [SB-1:0]        rout_q;

	logic [GB-1:0]        gcl_d;
	logic [SB-1:0]        smp;
	logic                 neg;
	logic [SB-1:0]        mag;
	logic [W-1:0]         a62;
	logic [W-1:0]         g62;
	logic [W-1:0]         tval;
	logic [W-1:0]         mul_a;
	logic [W-1:0]         mul_b;
	sagc_pkg::msh_t       mul_sh;
	logic                 mul_done;
	logic [W-1:0]         mres;
	logic                 div_done;
	logic [W-1:0]         quo;
	logic [SB-1:0]        omag;
	logic [SB-1:0]        ores;
	logic [GB-1:0]        delta;

	// the stored gain may stray outside the clamp; clamp only on use
	always_comb begin
		if (gain_q < sagc_pkg::GAIN_LO) begin
			gcl_d = sagc_pkg::GAIN_LO;
		end else if (gain_q > sagc_pkg::GAIN_ONE) begin
			gcl_d = sagc_pkg::GAIN_ONE;
		end else begin
			gcl_d = gain_q;
		end
	end

	always_comb begin
		smp  = cmd.ch ? r_q : l_q;
		neg  = smp[SB-1];
		mag  = neg ? (~smp + SB'(1)) : smp;
		a62  = W'(mag) << sagc_pkg::A_SH;
		g62  = W'(gcl_q) << sagc_pkg::G_SH;
		tval = x_q << 2;
		omag = mres[sagc_pkg::O_SH +: SB];
		ores = neg ? (~omag + SB'(1)) : omag;
		delta = mres[GB-1:0];
	end

	always_comb begin
		case (cmd.msel)
			sagc_pkg::MS_X: begin
				mul_a = a62;  mul_b = g62;  mul_sh = sagc_pkg::MSH_X;
			end
			sagc_pkg::MS_X2: begin
				mul_a = x_q;  mul_b = x_q;  mul_sh = sagc_pkg::MSH_Q;
			end
			sagc_pkg::MS_X4: begin
				mul_a = x4_q; mul_b = x4_q; mul_sh = sagc_pkg::MSH_Q;
			end
			sagc_pkg::MS_SN: begin
				mul_a = sagc_pkg::SIN4_MAG; mul_b = x4_q; mul_sh = sagc_pkg::MSH_D;
			end
			sagc_pkg::MS_T2: begin
				mul_a = tval; mul_b = tval; mul_sh = sagc_pkg::MSH_Q;
			end
			sagc_pkg::MS_SM: begin
				mul_a = t2_q; mul_b = u_q;  mul_sh = sagc_pkg::MSH_Q;
			end
			sagc_pkg::MS_S: begin
				mul_a = tval; mul_b = u_q;  mul_sh = sagc_pkg::MSH_Q;
			end
			sagc_pkg::MS_SP: begin
				mul_a = u_q;  mul_b = x4_q; mul_sh = sagc_pkg::MSH_D;
			end
			default: begin
				mul_a = '0;   mul_b = '0;   mul_sh = sagc_pkg::MSH_Q;
			end
		endcase
	end

	sagc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.sh     (mul_sh),
		.done   (mul_done),
		.res    (mres)
	);

	// series term division starts straight from the multiplier result
	sagc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (mres),
		.idx    (cmd.div_idx),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		stat.mul_done = mul_done;
		stat.div_done = div_done;
		stat.t_big    = tval > sagc_pkg::Q62_ONE;
	end

	assign left_out  = lout_q;
	assign right_out = rout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= sagc_pkg::GAIN_ONE;
		end else if (cmd.commit) begin
			gain_q <= gacc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			l_q    <= left_in;
			r_q    <= right_in;
			gcl_q  <= gcl_d;
			gacc_q <= gcl_d;
		end
		if (mul_done) begin
			case (cmd.msel)
				sagc_pkg::MS_X: begin
					x_q <= mres;
					if (cmd.ch) begin
						rres_q <= ores;
					end else begin
						lres_q <= ores;
					end
				end
				sagc_pkg::MS_X2: x4_q <= mres;
				sagc_pkg::MS_X4: x4_q <= mres;
				sagc_pkg::MS_SN: gacc_q <= gacc_q - delta;
				sagc_pkg::MS_T2: begin
					t2_q <= mres;
					u_q  <= sagc_pkg::Q62_ONE;
				end
				sagc_pkg::MS_S:  u_q <= mres;
				sagc_pkg::MS_SP: gacc_q <= gacc_q + delta;
				default: ;
			endcase
		end
		if (div_done) begin
			u_q <= sagc_pkg::Q62_ONE - quo;
		end
		if (cmd.commit) begin
			lout_q <= lres_q;
			rout_q <= rres_q;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/sagc_ctrl.sv
`default_nettype none
`include "stereo_adaptive_gain_compressor_unit_assert.svh"
// ----------------------------------------------------------------------------
// sagc_ctrl
// Sequencer: accepts a sample pair, steps each channel through the multiply
// and sine series schedule, then hands the pair to the output register.
// ----------------------------------------------------------------------------
module sagc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output sagc_pkg::cmd_t       cmd,
	input  wire sagc_pkg::stat_t stat
);

	localparam int TB = sagc_pkg::TERM_BITS;
	localparam logic [TB-1:0] TERM_LAST = TB'(sagc_pkg::SINE_TERMS - 1);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_X    = 11'b000_0000_0010,
		S_X2   = 11'b000_0000_0100,
		S_X4   = 11'b000_0000_1000,
		S_SN   = 11'b000_0001_0000,
		S_T2   = 11'b000_0010_0000,
		S_SM   = 11'b000_0100_0000,
		S_SD   = 11'b000_1000_0000,
		S_S    = 11'b001_0000_0000,
		S_SP   = 11'b010_0000_0000,
		S_FIN  = 11'b100_0000_0000
	} state_t;

	state_t         state_q;
	state_t         state_d;
	logic           ch_q;
	logic           ch_d;
	logic [TB-1:0]  idx_q;
	logic [TB-1:0]  idx_d;
	logic           out_valid_q;

	always_comb begin
		state_d     = state_q;
		ch_d        = ch_q;
		idx_d       = idx_q;
		cmd         = '0;
		cmd.ch      = ch_q;
		cmd.div_idx = idx_q;
		cmd.msel    = sagc_pkg::MS_X;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					ch_d     = 1'b0;
					state_d  = S_X;
				end
			end
			S_X: begin
				cmd.mul_go = 1'b1;
				cmd.msel   = sagc_pkg::MS_X;
				if (stat.mul_done) begin
					state_d = S_X2;
				end
			end
			S_X2: begin
				cmd.mul_go = 1'b1;
				cmd.msel   = sagc_pkg::MS_X2;
				if (stat.mul_done) begin
					state_d = S_X4;
				end
			end
			S_X4: begin
				cmd.mul_go = 1'b1;
				cmd.msel   = sagc_pkg::MS_X4;
				if (stat.mul_done) begin
					state_d = stat.t_big ? S_SN : S_T2;
				end
			end
			S_SN: begin
				cmd.mul_go = 1'b1;
				cmd.msel   = sagc_pkg::MS_SN;
				if (stat.mul_done) begin
					if (ch_q) begin
						state_d = S_FIN;
					end else begin
						ch_d    = 1'b1;
						state_d = S_X;
					end
				end
			end
			S_T2: begin
				cmd.mul_go = 1'b1;
				cmd.msel   = sagc_pkg::MS_T2;
				if (stat.mul_done) begin
					idx_d   = '0;
					state_d = S_SM;
				end
			end
			S_SM: begin
				cmd.mul_go = 1'b1;
				cmd.msel   = sagc_pkg::MS_SM;
				cmd.div_go = stat.mul_done;
				if (stat.mul_done) begin
					state_d = S_SD;
				end
			end
			S_SD: begin
				if (stat.div_done) begin
					if (idx_q == TERM_LAST) begin
						state_d = S_S;
					end else begin
						idx_d   = idx_q + TB'(1);
						state_d = S_SM;
					end
				end
			end
			S_S: begin
				cmd.mul_go = 1'b1;
				cmd.msel   = sagc_pkg::MS_S;
				if (stat.mul_done) begin
					state_d = S_SP;
				end
			end
			S_SP: begin
				cmd.mul_go = 1'b1;
				cmd.msel   = sagc_pkg::MS_SP;
				if (stat.mul_done) begin
					if (ch_q) begin
						state_d = S_FIN;
					end else begin
						ch_d    = 1'b1;
						state_d = S_X;
					end
				end
			end
			S_FIN: begin
				// wait only if the previous item is still held in the output
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			idx_q   <= idx_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SAGC_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid_q, "commit did not raise out_valid")
	`SAGC_ASSERT_IMP(a_div_done_state, stat.div_done, state_q == S_SD, "divider done outside wait")
	`SAGC_ASSERT_NEVER(a_units_overlap, stat.mul_done && stat.div_done, "mul and div done together")

endmodule
`default_nettype wire

### test/tb_stereo_adaptive_gain_compressor_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_adaptive_gain_compressor_unit
// Drives stereo pairs through the compressor under several idle and stall
// mixes. A bit-exact fixed-point model of the shared gain predicts every
// output pair without a typed result, and the outputs are checked in order.
// ----------------------------------------------------------------------------
module tb_stereo_adaptive_gain_compressor_unit;

	localparam int SB = sagc_pkg::SAMPLE_BITS;
	localparam int GF = 30;
	localparam int PHASES = 4;
	localparam int ITEMS_PER_PHASE = 420;
	localparam int DRAIN_CYCLES = 400;
	localparam int N_ROWS = 20;

	typedef logic [63:0] u64_t;

	localparam u64_t Q62_UNIT = 64'h4000_0000_0000_0000;
	localparam u64_t SINE4_NEG_MAG = 64'd3490135486322531555;
	localparam logic signed [63:0] GAIN_UNITY = 64'sd1 <<< GF;
	localparam logic signed [63:0] GAIN_FLOOR = 64'sd1 <<< (GF - 7);

	localparam int IDLE_PCT [PHASES] = '{0, 46, 0, 14};
	localparam int STALL_PCT[PHASES] = '{0, 0, 46, 14};

	typedef enum int {
		LVL_QUIET,
		LVL_MID,
		LVL_LOUD,
		LVL_EDGE,
		LVL_ANY
	} level_t;

	typedef struct packed {
		logic signed [SB-1:0] left_s;
		logic signed [SB-1:0] right_s;
	} sample_pair_t;

	typedef struct packed {
		logic [SB-1:0]        y;
		logic signed [63:0]   step;
	} chan_res_t;

	typedef struct packed {
		sample_pair_t stim;
		logic         known;
		sample_pair_t want;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [SB-1:0] left_in;
	logic signed [SB-1:0] right_in;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [SB-1:0] left_out;
	logic signed [SB-1:0] right_out;

	sample_pair_t       scaled_q[$];
	logic signed [63:0] gain_q30;
	int                 mismatches;
	int                 idle_pct;
	int                 stall_pct;

	// Rows with a typed result run while the gain sits at (or is clamped to) unity
	// or have zero input; the rest are checked against the gain model.
	row_t dir_rows [N_ROWS] = '{
		'{'{24'h000000, 24'h000000}, 1'b1, '{24'h000000, 24'h000000}},
		'{'{24'h400000, 24'hC00000}, 1'b1, '{24'h400000, 24'hC00000}},
		'{'{24'h800000, 24'h7FFFFF}, 1'b1, '{24'h800000, 24'h7FFFFF}},
		'{'{24'h000000, 24'h000000}, 1'b1, '{24'h000000, 24'h000000}},
		'{'{24'h800000, 24'h800000}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h7FFFFF, 24'h7FFFFF}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h000001, 24'hFFFFFF}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'hFFFFFF, 24'h000001}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h7FFFFF, 24'h000000}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h000000, 24'h800000}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'hAAAAAA, 24'h555555}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h555555, 24'hAAAAAA}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h200000, 24'hE00000}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h100000, 24'h080000}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h123456, 24'h654321}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'hF0F0F0, 24'h0F0F0F}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h000100, 24'hFFFF00}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h400000, 24'h400000}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h800000, 24'h000001}, 1'b0, '{24'h000000, 24'h000000}},
		'{'{24'h000000, 24'h000000}, 1'b1, '{24'h000000, 24'h000000}}
	};

	stereo_adaptive_gain_compressor_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.left_in   (left_in),
		.right_in  (right_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.left_out  (left_out),
		.right_out (right_out)
	);

	always #10 clk = ~clk;

	// (a * b) >> sh over the full 128-bit product, kept to 64 bits
	function automatic u64_t mul_shr(input u64_t a, input u64_t b, input int unsigned sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> sh;
		return p[63:0];
	endfunction

	// truncated Taylor series of sin(t), t in [0, 1], Q0.62
	function automatic u64_t series_sine(input u64_t t);
		u64_t t2;
		u64_t u;
		u64_t divs [6];
		divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
		t2 = mul_shr(t, t, 62);
		u = Q62_UNIT;
		for (int i = 0; i < 6; i++)
			u = Q62_UNIT - mul_shr(t2, u, 62) / divs[i];
		return mul_shr(t, u, 62);
	endfunction

	function automatic chan_res_t scale_channel(input logic [SB-1:0] raw, input u64_t g62);
		chan_res_t    r;
		logic         neg;
		logic [SB-1:0] inv;
		u64_t         mag;
		u64_t         x;
		u64_t         t;
		u64_t         x4;
		u64_t         omag;
		neg = raw[SB-1];
		inv = ~raw;
		mag = neg ? {{(64-SB){1'b0}}, inv} + 64'd1 : {{(64-SB){1'b0}}, raw};
		x = mul_shr(mag << (63 - SB), g62, 63);
		t = x << 2;
		x4 = mul_shr(x, x, 62);
		x4 = mul_shr(x4, x4, 62);
		omag = x >> (62 - SB);
		if (t > Q62_UNIT)
			r.step = -mul_shr(SINE4_NEG_MAG, x4, 124 - GF);
		else
			r.step = mul_shr(series_sine(t), x4, 124 - GF);
		r.y = neg ? (~omag[SB-1:0]) + 1'b1 : omag[SB-1:0];
		return r;
	endfunction

	// one sample pair through the gain model; advances gain_q30
	function automatic sample_pair_t compress_pair(input sample_pair_t s);
		logic signed [63:0] g;
		u64_t               g62;
		chan_res_t          lc;
		chan_res_t          rc;
		sample_pair_t       o;
		g = gain_q30;
		if (g < GAIN_FLOOR)
			g = GAIN_FLOOR;
		if (g > GAIN_UNITY)
			g = GAIN_UNITY;
		g62 = g;
		g62 = g62 << (62 - GF);
		lc = scale_channel(s.left_s, g62);
		rc = scale_channel(s.right_s, g62);
		gain_q30 = g + lc.step + rc.step;
		o.left_s = lc.y;
		o.right_s = rc.y;
		return o;
	endfunction

	function automatic logic [SB-1:0] pick_sample(input level_t lvl);
		logic [SB-1:0] mag;
		case (lvl)
			LVL_QUIET: mag = SB'($urandom_range(0, 1 << 18));
			LVL_MID:   mag = SB'($urandom_range(1 << 21, 3 << 21));
			LVL_LOUD:  mag = SB'($urandom_range(6 << 20, (1 << 23) - 1));
			LVL_EDGE: begin
				case ($urandom_range(0, 4))
					0:       return 24'h000000;
					1:       return 24'h7FFFFF;
					2:       return 24'h800000;
					3:       return 24'h000001;
					default: return 24'hFFFFFF;
				endcase
			end
			default:   return SB'($urandom());
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	task automatic send_pair(input sample_pair_t stim, input logic known,
		input sample_pair_t want);
		sample_pair_t pred;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_in  <= stim.left_s;
		right_in <= stim.right_s;
		do @(posedge clk); while (in_stall);
		pred = compress_pair(stim);
		scaled_q.push_back(known ? want : pred);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (scaled_q.size() != 0);
	endtask

	// output checker; also randomizes the receiver stall for the next cycle
	always @(posedge clk) begin
		sample_pair_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (scaled_q.size() == 0) begin
				$error("unexpected item: left_out %0d right_out %0d", left_out, right_out);
				mismatches++;
			end else begin
				want = scaled_q.pop_front();
				if (left_out !== want.left_s) begin
					$error("left_out: expected %0d, got %0d", want.left_s, left_out);
					mismatches++;
				end
				if (right_out !== want.right_s) begin
					$error("right_out: expected %0d, got %0d", want.right_s, right_out);
					mismatches++;
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		#100_000_000;
		$display("tb_stereo_adaptive_gain_compressor_unit failed");
		$finish;
	end

	initial begin
		int           sent;
		int           run_len;
		level_t       lvl_l;
		level_t       lvl_r;
		sample_pair_t stim;
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		left_in    = '0;
		right_in   = '0;
		out_stall  = 1'b0;
		mismatches = 0;
		idle_pct   = 0;
		stall_pct  = 0;
		gain_q30   = GAIN_UNITY;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_pair(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].want);
		hold_until_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_pct  = IDLE_PCT[ph];
			stall_pct = STALL_PCT[ph];
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				// bursts of one loudness let the gain settle high or low before it flips
				lvl_l = level_t'($urandom_range(0, 4));
				lvl_r = $urandom_range(0, 2) == 0 ? level_t'($urandom_range(0, 4)) : lvl_l;
				run_len = $urandom_range(1, 24);
				for (int k = 0; k < run_len; k++) begin
					stim.left_s  = pick_sample(lvl_l);
					stim.right_s = pick_sample(lvl_r);
					send_pair(stim, 1'b0, '0);
					sent++;
				end
			end
			hold_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_stereo_adaptive_gain_compressor_unit passed");
		else
			$display("tb_stereo_adaptive_gain_compressor_unit failed");
		$finish;
	end

endmodule

### stereo_adaptive_gain_compressor_unit.f
+incdir+hw/rtl
hw/rtl/sagc_pkg.sv
hw/rtl/sagc_mul.sv
hw/rtl/sagc_div.sv
hw/rtl/sagc_dp.sv
hw/rtl/sagc_ctrl.sv
hw/rtl/stereo_adaptive_gain_compressor_unit.sv
test/tb_stereo_adaptive_gain_compressor_unit.sv
